@@ hdl/lcgks_pkg.sv @@
`timescale 1ns / 1ps

package lcgks_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_ADD_KEY   = 2'd2,
        CFG_MULT_KEY  = 2'd3
    } cfg_idx_t;

    localparam word_t RST_THRESHOLD = 32'd1000000;
    localparam word_t RST_ADD_KEY   = 32'h3C6E_F35F;
    localparam word_t RST_MULT_KEY  = 32'h0019_660D;

endpackage

@@ hdl/lcg_keystream_header_cipher_unit.sv @@
`timescale 1ns / 1ps
// A word passes the input register, then the result register, on its way to the output.
// Throughput: one word per cycle while the result side is not stalled; the key update (one
// 32x32 multiply-add) sits in the single stage between the input register and the result register.
// Words that produce no result (decrypt surplus or zero count) leave without an output.
// Reset (aresetn low, synchronous) empties both stages, clears key, checksum and count,
// and restores the register defaults.
module lcg_keystream_header_cipher_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lcgks_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lcgks_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lcgks_pkg::WORD_W-1:0]    s_data_word,
    input  logic                            s_start_of_header,
    input  logic                            s_final_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lcgks_pkg::WORD_W-1:0]    m_out_word,
    output logic                            m_last_of_header
);
    import lcgks_pkg::*;

    // configuration
    logic  direction_reg;
    word_t threshold_reg;
    word_t add_key_reg;
    word_t mult_key_reg;

    // input stage
    logic  in_valid_reg;
    word_t in_word_reg;
    logic  in_start_reg;
    logic  in_final_reg;

    // running state
    word_t key_reg, key_next;
    word_t cks_reg, cks_next;
    word_t left_reg, left_next;
    logic  enc_reg, enc_next;

    // result stage
    logic  out_valid_reg;
    word_t out_word_reg, out_word_next;
    logic  out_last_reg, out_last_next;
    logic  res_valid;

    logic  advance;
    word_t key_base;
    word_t cks_base;
    word_t key_step;
    word_t left_base;
    logic  enc_base;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            threshold_reg <= RST_THRESHOLD;
            add_key_reg   <= RST_ADD_KEY;
            mult_key_reg  <= RST_MULT_KEY;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DIRECTION: direction_reg <= cfg_wdata[0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_ADD_KEY:   add_key_reg   <= cfg_wdata;
                CFG_MULT_KEY:  mult_key_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        key_base  = in_start_reg ? '0 : key_reg;
        cks_base  = in_start_reg ? '0 : cks_reg;
        key_step  = word_t'(key_base * mult_key_reg) + add_key_reg;
        enc_base  = enc_reg;
        left_base = left_reg;

        key_next      = key_base;
        cks_next      = cks_base;
        left_next     = left_reg;
        enc_next      = enc_reg;
        res_valid     = 1'b0;
        out_word_next = in_word_reg;
        out_last_next = 1'b0;

        if (direction_reg) begin
            res_valid = 1'b1;
            if (in_final_reg) begin
                out_word_next = cks_base ^ key_base;
                out_last_next = 1'b1;
            end else begin
                cks_next      = cks_base + in_word_reg;
                key_next      = key_step;
                out_word_next = in_word_reg ^ key_step;
            end
        end else begin
            if (in_start_reg) begin
                enc_base  = in_word_reg > threshold_reg;
                left_base = enc_base ? (in_word_reg ^ add_key_reg) : in_word_reg;
            end
            enc_next  = enc_base;
            left_next = left_base;
            // drop the word when the count is exhausted
            if (left_base != '0) begin
                res_valid     = 1'b1;
                left_next     = left_base - word_t'(1);
                out_last_next = (left_base == word_t'(1));
                if (enc_base) begin
                    key_next      = key_step;
                    out_word_next = in_word_reg ^ key_step;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            cks_reg       <= '0;
            left_reg      <= '0;
            enc_reg       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= res_valid;
                key_reg       <= key_next;
                cks_reg       <= cks_next;
                left_reg      <= left_next;
                enc_reg       <= enc_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg  <= s_data_word;
            in_start_reg <= s_start_of_header;
            in_final_reg <= s_final_word;
        end
        if (advance && res_valid) begin
            out_word_reg <= out_word_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_word       = out_word_reg;
    assign m_last_of_header = out_last_reg;

endmodule

@@ hdl/lcgks_checker.sv @@
`timescale 1ns / 1ps

module lcgks_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lcgks_pkg::WORD_W-1:0]    m_out_word,
    input logic                            m_last_of_header
);
    import lcgks_pkg::*;

    // hold the result while the sink stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_word) && $stable(m_last_of_header))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side drains");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("stages not empty after reset");

endmodule

bind lcg_keystream_header_cipher_unit lcgks_checker u_lcgks_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_out_word       (m_out_word),
    .m_last_of_header (m_last_of_header)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lcgks_pkg::*;

    localparam bit DIR_DECRYPT  = 1'b0;
    localparam bit DIR_ENCRYPT  = 1'b1;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        word_t word;
        logic  last;
    } cipher_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_DIRECTION;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_data_word = '0;
    logic                 s_start_of_header = 1'b0;
    logic                 s_final_word = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WORD_W-1:0]    m_out_word;
    logic                 m_last_of_header;

    // register mirror
    bit    mode_encrypt;
    word_t key_threshold;
    word_t key_add;
    word_t key_mult;

    // cipher state mirror
    word_t key_now;
    word_t sum_now;
    word_t count_left;
    bit    hdr_encrypted;

    cipher_out_t expected_words[$];

    int error_count  = 0;
    int words_sent   = 0;
    int stuck_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    lcg_keystream_header_cipher_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_word       (s_data_word),
        .s_start_of_header (s_start_of_header),
        .s_final_word      (s_final_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_word        (m_out_word),
        .m_last_of_header  (m_last_of_header)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    // Work out the result of one accepted word and advance the state mirror
    function automatic void cipher_word(word_t w, bit sop, bit is_final);
        cipher_out_t r;
        if (sop) begin
            key_now = '0;
            sum_now = '0;
        end
        if (mode_encrypt == DIR_ENCRYPT) begin
            if (is_final) begin
                r.word = sum_now ^ key_now;
                r.last = 1'b1;
            end else begin
                sum_now = sum_now + w;
                key_now = key_now * key_mult + key_add;
                r.word  = w ^ key_now;
                r.last  = 1'b0;
            end
            expected_words = {expected_words, r};
            return;
        end
        if (sop) begin
            hdr_encrypted = w > key_threshold;
            count_left    = hdr_encrypted ? (w ^ key_add) : w;
        end
        // surplus word or zero count: nothing comes out
        if (count_left == '0) return;
        count_left = count_left - 1;
        if (hdr_encrypted) begin
            key_now = key_now * key_mult + key_add;
            r.word  = w ^ key_now;
        end else begin
            r.word = w;
        end
        r.last = (count_left == '0);
        expected_words = {expected_words, r};
    endfunction

    task automatic send_word(word_t w, bit sop, bit is_final);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid           <= 1'b1;
        s_data_word       <= w;
        s_start_of_header <= sop;
        s_final_word      <= is_final;
        do @(posedge aclk); while (s_ready !== 1'b1);
        cipher_word(w, sop, is_final);
        words_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let silent words flush
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(bit dir, word_t thr, word_t add, word_t mult);
        cfg_idx_t regs[4];
        word_t    vals[4];
        regs = '{CFG_DIRECTION, CFG_THRESHOLD, CFG_ADD_KEY, CFG_MULT_KEY};
        vals = '{word_t'(dir), thr, add, mult};
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (regs[i])
                CFG_DIRECTION: mode_encrypt  = vals[i][0];
                CFG_THRESHOLD: key_threshold = vals[i];
                CFG_ADD_KEY:   key_add       = vals[i];
                CFG_MULT_KEY:  key_mult      = vals[i];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic send_dec_header();
        int unsigned count;
        int unsigned body;
        word_t       plain_first;
        word_t       enc_first;
        word_t       first;
        bit          plain_ok;
        bit          enc_ok;
        count       = ($urandom_range(15) == 0) ? 0 : $urandom_range(12, 1);
        plain_first = word_t'(count);
        enc_first   = word_t'(count) ^ key_add;
        plain_ok    = plain_first <= key_threshold;
        enc_ok      = enc_first > key_threshold;
        if (plain_ok && (!enc_ok || $urandom_range(1))) first = plain_first;
        else if (enc_ok) first = enc_first;
        else first = $urandom;
        body = (count == 0) ? 0 : count - 1;
        // cut the header short now and then
        if ($urandom_range(9) == 0) body = $urandom_range(body, 0);
        // add a few surplus words past the count
        if ($urandom_range(4) == 0) body += $urandom_range(3, 1);
        send_word(first, 1'b1, 1'($urandom_range(1)));
        repeat (body) send_word($urandom, 1'b0, 1'($urandom_range(1)));
    endtask

    task automatic send_enc_header();
        int unsigned body;
        if ($urandom_range(14) == 0) begin
            send_word($urandom, 1'b1, 1'b1);
        end else begin
            send_word($urandom, 1'b1, 1'b0);
            body = $urandom_range(10);
            repeat (body) send_word($urandom, 1'b0, 1'b0);
            if ($urandom_range(9) != 0) send_word($urandom, 1'b0, 1'b1);
        end
        // carry on past the checksum word now and then
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(2, 1)) send_word($urandom, 1'b0, 1'b0);
        end
    endtask

    task automatic run_random(int n_items);
        int target;
        target = words_sent + n_items;
        while (words_sent < target) begin
            if ($urandom_range(99) < 10) begin
                send_word($urandom, $urandom_range(7) == 0, $urandom_range(3) == 0);
            end else if (mode_encrypt == DIR_ENCRYPT) begin
                send_enc_header();
            end else begin
                send_dec_header();
            end
        end
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(20));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        // decrypt with reset defaults
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'd3, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(RST_ADD_KEY, 1'b1, 1'b0);
        send_word(RST_ADD_KEY ^ 32'd2, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(RST_THRESHOLD, 1'b1, 1'b0);
        send_word(RST_THRESHOLD + 1, 1'b1, 1'b0);
        send_word(32'h5A5A_5A5A, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        configure(DIR_ENCRYPT, RST_THRESHOLD, RST_ADD_KEY, RST_MULT_KEY);
        send_word(32'h1234_5678, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hDEAD_BEEF, 1'b0, 1'b1);
        send_word(32'h0BAD_F00D, 1'b0, 1'b0);
        send_word(32'h7777_7777, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h1357_9BDF, 1'b0, 1'b0);
        // switch back mid header: the long count from above still stands
        configure(DIR_DECRYPT, RST_THRESHOLD, RST_ADD_KEY, RST_MULT_KEY);
        send_word(32'h2468_ACE0, 1'b0, 1'b0);
        send_word(32'h1111_1111, 1'b0, 1'b0);
    endtask

    task automatic test_decrypt_random();
        configure(DIR_DECRYPT, RST_THRESHOLD, RST_ADD_KEY, RST_MULT_KEY);
        run_random(400);
    endtask

    task automatic test_encrypt_random();
        configure(DIR_ENCRYPT, RST_THRESHOLD, RST_ADD_KEY, RST_MULT_KEY);
        run_random(400);
    endtask

    task automatic test_key_extremes();
        configure(DIR_DECRYPT, '0, '1, '1);
        run_random(70);
        configure(DIR_DECRYPT, '1, '0, '0);
        run_random(70);
        configure(DIR_ENCRYPT, '0, '0, 32'd1);
        run_random(70);
        configure(DIR_ENCRYPT, '1, '1, '0);
        run_random(70);
        configure(DIR_DECRYPT, 32'd20, 32'd1, 32'd1);
        run_random(70);
        configure(DIR_ENCRYPT, RST_THRESHOLD, $urandom, '1);
        run_random(70);
    endtask

    task automatic test_backpressure();
        configure(DIR_ENCRYPT, RST_THRESHOLD, $urandom, $urandom);
        // hold the result side off while words keep coming
        hold_asked++;
        run_random(150);
    endtask

    task automatic test_mixed_random();
        repeat (5) begin
            configure(1'($urandom_range(1)), pick_word(), pick_word(), pick_word());
            run_random(100);
        end
    endtask

    initial begin
        mode_encrypt  = DIR_DECRYPT;
        key_threshold = RST_THRESHOLD;
        key_add       = RST_ADD_KEY;
        key_mult      = RST_MULT_KEY;
        key_now       = '0;
        sum_now       = '0;
        count_left    = '0;
        hdr_encrypted = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        set_idle(8, 60);
        test_directed();
        test_decrypt_random();
        set_idle(60, 8);
        test_encrypt_random();
        test_key_extremes();
        set_idle(0, 0);
        test_backpressure();
        test_mixed_random();
        settle();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold when asked
    always @(posedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        cipher_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result %h last %b with nothing expected",
                                          m_out_word, m_last_of_header));
            end else begin
                want = expected_words.pop_front();
                if (m_out_word !== want.word) begin
                    report_mismatch($sformatf("out_word %h, expected %h",
                                              m_out_word, want.word));
                end
                if (m_last_of_header !== want.last) begin
                    report_mismatch($sformatf("last_of_header %b, expected %b",
                                              m_last_of_header, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
